[hw/rtl/rncw_pkg.sv]
// Package of the RIFF nested chunk walker: sizes, fourcc constants,
// parse phases, event kinds and the command item between front and back.
// No dependencies.
package rncw_pkg;

  localparam int unsigned MAX_LEVELS = 10;
  localparam int unsigned LVL_W      = 4;
  localparam int unsigned SIZE_W     = 32;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned HDR_BYTES  = 12;
  localparam int unsigned WORD_BYTES = 4;

  localparam logic [31:0] CC_RIFF = 32'h4646_4952;
  localparam logic [31:0] CC_LIST = 32'h5453_494C;
  localparam logic [31:0] CC_INFO = 32'h4F46_4E49;
  localparam logic [31:0] CC_MOVI = 32'h6976_6F6D;

  localparam logic [CFG_IDX_W-1:0] REG_FORMAT = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH = 8'd1;

  typedef enum logic [2:0] {
    EV_PAYLOAD   = 3'd0,
    EV_LIST      = 3'd1,
    EV_LIST_END  = 3'd2,
    EV_CHUNK     = 3'd3,
    EV_END       = 3'd4,
    EV_HDR_ERR   = 3'd5,
    EV_OVERFLOW  = 3'd6,
    EV_UNDERFLOW = 3'd7
  } rncw_kind_e;

  typedef enum logic [7:0] {
    PH_HDR     = 8'b0000_0001,
    PH_ID      = 8'b0000_0010,
    PH_LSIZE   = 8'b0000_0100,
    PH_LTYPE   = 8'b0000_1000,
    PH_CSIZE   = 8'b0001_0000,
    PH_PAYLOAD = 8'b0010_0000,
    PH_SKIP    = 8'b0100_0000,
    PH_DONE    = 8'b1000_0000
  } rncw_phase_e;

  typedef struct packed {
    logic              ufl_v;
    logic [LVL_W-1:0]  ufl_lvl;
    logic              main_v;
    rncw_kind_e        kind;
    logic [LVL_W-1:0]  lvl;
    logic [31:0]       id;
    logic [31:0]       lk;
    logic [31:0]       size;
    logic [7:0]        pb;
    logic [LVL_W-1:0]  end_hi;
    logic [LVL_W-1:0]  end_lo;
    logic              fin_v;
  } rncw_cmd_t;

endpackage

[hw/rtl/riff_nested_chunk_walker.sv]
// Top level of the RIFF nested chunk walker: front parser, command queue
// and event sequencer. Uses rncw_pkg, rncw_front, rncw_fifo, rncw_back.
//
//   channel   direction  handshake               payload
//   cfg       in         cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//   in        in         in_valid_i/in_ready_o   data_byte_i
//   out       out        out_valid_o/out_ready_i event fields, last_o
//
// The front takes one byte a cycle while the two-entry queue has room.
// The back sends one event a cycle while the output register is free or
// taken; a byte causes at most twelve events, and long bursts of list ends
// stall the input through the queue.
// Reset clears all control state and the level counters at once.
// Configuration writes are always taken.
module riff_nested_chunk_walker import rncw_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]          cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [7:0]           data_byte_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [2:0]           event_kind_o,
  output logic [LVL_W-1:0]     nest_level_o,
  output logic [31:0]          chunk_id_o,
  output logic [31:0]          list_kind_o,
  output logic [31:0]          chunk_size_o,
  output logic [7:0]           payload_byte_o,
  output logic                 last_o
);

  rncw_cmd_t f_cmd, q_cmd;
  logic      f_push, q_full, q_valid, q_pop;

  assign cfg_ready_o = 1'b1;

  rncw_front u_front (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .data_byte_i,
    .cmd_valid_o(f_push), .cmd_o(f_cmd), .cmd_full_i(q_full)
  );

  rncw_fifo u_fifo (
    .clk_i, .rst_ni, .push_i(f_push), .data_i(f_cmd), .full_o(q_full),
    .pop_i(q_pop), .valid_o(q_valid), .data_o(q_cmd)
  );

  rncw_back u_back (
    .clk_i, .rst_ni, .cmd_valid_i(q_valid), .cmd_i(q_cmd), .cmd_pop_o(q_pop),
    .out_valid_o, .out_ready_i, .event_kind_o, .nest_level_o, .chunk_id_o,
    .list_kind_o, .chunk_size_o, .payload_byte_o, .last_o
  );

endmodule

[hw/rtl/rncw_front.sv]
// Front part of the walker: takes stream bytes, keeps the level counters
// and phase, and turns each byte into at most one command item. Uses rncw_pkg.
module rncw_front import rncw_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]          cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [7:0]           data_byte_i,
  output logic                 cmd_valid_o,
  output rncw_cmd_t            cmd_o,
  input  logic                 cmd_full_i
);

  logic [31:0]       fmt_q, len_q;
  rncw_phase_e       phase_q, phase_n;
  logic [3:0]        fbc_q, fbc_n;
  logic [31:0]       id_q, id_n, size_q, size_n, skip_q, skip_n;
  logic [LVL_W-1:0]  cur_q, cur_n;
  logic [SIZE_W-1:0] lr_q [MAX_LEVELS];
  logic [SIZE_W-1:0] lr_n [MAX_LEVELS];
  logic              bad_q, bad_n;
  logic              accept;
  rncw_cmd_t         cmd;

  assign in_ready_o = !cmd_full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    logic             cons;
    logic             bnd;
    logic             found;
    logic [LVL_W-1:0] nc;
    phase_n = phase_q;
    fbc_n   = fbc_q;
    id_n    = id_q;
    size_n  = size_q;
    skip_n  = skip_q;
    cur_n   = cur_q;
    bad_n   = bad_q;
    lr_n    = lr_q;
    cmd     = '0;
    bnd     = 1'b0;
    found   = 1'b0;
    nc      = '0;
    cons    = (phase_q != PH_HDR) && (phase_q != PH_DONE);
    if (cons) begin
      for (int i = 0; i < MAX_LEVELS; i++) begin
        if (LVL_W'(i) <= cur_q) begin
          if (lr_q[i] != '0) begin
            lr_n[i] = lr_q[i] - 1'b1;
          end else if (!found) begin
            found       = 1'b1;
            cmd.ufl_v   = 1'b1;
            cmd.ufl_lvl = LVL_W'(i);
          end
        end
      end
    end
    unique case (phase_q)
      PH_HDR: begin
        if (fbc_q < 4'(WORD_BYTES)) id_n = {data_byte_i, id_q[31:8]};
        else size_n = {data_byte_i, size_q[31:8]};
        if (fbc_q == 4'd3) bad_n = ({data_byte_i, id_q[31:8]} != CC_RIFF);
        fbc_n = fbc_q + 1'b1;
        if (fbc_n >= 4'(HDR_BYTES)) begin
          if (bad_n || size_n != fmt_q || len_q < 32'(HDR_BYTES)) begin
            cmd.main_v = 1'b1;
            cmd.kind   = EV_HDR_ERR;
            phase_n    = PH_DONE;
          end else begin
            cur_n    = '0;
            lr_n[0]  = len_q - 32'(HDR_BYTES);
            bnd      = 1'b1;
          end
        end
      end
      PH_ID: begin
        id_n  = {data_byte_i, id_q[31:8]};
        fbc_n = fbc_q + 1'b1;
        if (fbc_n >= 4'(WORD_BYTES)) begin
          fbc_n = '0;
          if (id_n == CC_LIST) phase_n = PH_LSIZE;
          else if (id_n == CC_INFO) bnd = 1'b1;
          else phase_n = PH_CSIZE;
        end
      end
      PH_LSIZE: begin
        size_n = {data_byte_i, size_q[31:8]};
        fbc_n  = fbc_q + 1'b1;
        if (fbc_n >= 4'(WORD_BYTES)) begin
          fbc_n = '0;
          if (5'(cur_q) + 5'd1 >= 5'(MAX_LEVELS)) begin
            cmd.main_v = 1'b1;
            cmd.kind   = EV_OVERFLOW;
            cmd.lvl    = cur_q;
            cmd.id     = CC_LIST;
            cmd.size   = size_n;
            skip_n     = size_n;
            if (size_n == '0) bnd = 1'b1;
            else phase_n = PH_SKIP;
          end else begin
            cur_n        = cur_q + 1'b1;
            lr_n[cur_n]  = size_n;
            id_n         = '0;
            phase_n      = PH_LTYPE;
          end
        end
      end
      PH_LTYPE: begin
        id_n  = {data_byte_i, id_q[31:8]};
        fbc_n = fbc_q + 1'b1;
        if (fbc_n >= 4'(WORD_BYTES)) begin
          fbc_n      = '0;
          cmd.main_v = 1'b1;
          cmd.kind   = EV_LIST;
          cmd.lvl    = cur_q;
          cmd.id     = CC_LIST;
          cmd.lk     = id_n;
          cmd.size   = size_q;
          if (id_n == CC_MOVI) begin
            skip_n = lr_n[cur_q];
            if (skip_n == '0) bnd = 1'b1;
            else phase_n = PH_SKIP;
          end else begin
            bnd = 1'b1;
          end
        end
      end
      PH_CSIZE: begin
        size_n = {data_byte_i, size_q[31:8]};
        fbc_n  = fbc_q + 1'b1;
        if (fbc_n >= 4'(WORD_BYTES)) begin
          fbc_n      = '0;
          cmd.main_v = 1'b1;
          cmd.kind   = EV_CHUNK;
          cmd.lvl    = cur_q;
          cmd.id     = id_q;
          cmd.size   = size_n;
          skip_n     = size_n;
          if (size_n == '0) bnd = 1'b1;
          else phase_n = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD, PH_SKIP: begin
        if (phase_q == PH_PAYLOAD) begin
          cmd.main_v = 1'b1;
          cmd.kind   = EV_PAYLOAD;
          cmd.lvl    = cur_q;
          cmd.id     = id_q;
          cmd.size   = size_q;
          cmd.pb     = data_byte_i;
        end
        if (skip_q != '0) skip_n = skip_q - 1'b1;
        if (skip_n == '0) bnd = 1'b1;
      end
      default: phase_n = PH_DONE;
    endcase
    if (bnd) begin
      for (int j = 1; j < MAX_LEVELS; j++) begin
        if (LVL_W'(j) <= cur_n && lr_n[j] != '0) nc = LVL_W'(j);
      end
      cmd.end_hi = cur_n;
      cmd.end_lo = nc;
      cur_n      = nc;
      fbc_n      = '0;
      if (nc == '0 && lr_n[0] == '0) begin
        cmd.fin_v = 1'b1;
        phase_n   = PH_DONE;
      end else begin
        phase_n = PH_ID;
      end
    end
  end

  assign cmd_o       = cmd;
  assign cmd_valid_o = accept && (phase_q != PH_DONE) &&
                       (cmd.ufl_v || cmd.main_v || cmd.fin_v || cmd.end_hi != cmd.end_lo);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q   <= '0;
      len_q   <= '0;
      phase_q <= PH_HDR;
      fbc_q   <= '0;
      id_q    <= '0;
      size_q  <= '0;
      skip_q  <= '0;
      cur_q   <= '0;
      bad_q   <= 1'b0;
      for (int i = 0; i < MAX_LEVELS; i++) lr_q[i] <= '0;
    end else begin
      if (cfg_valid_i) begin
        if (cfg_index_i == REG_FORMAT) fmt_q <= cfg_data_i;
        else if (cfg_index_i == REG_LENGTH) len_q <= cfg_data_i;
      end
      if (accept) begin
        phase_q <= phase_n;
        fbc_q   <= fbc_n;
        id_q    <= id_n;
        size_q  <= size_n;
        skip_q  <= skip_n;
        cur_q   <= cur_n;
        bad_q   <= bad_n;
        lr_q    <= lr_n;
      end
    end
  end

endmodule

[hw/rtl/rncw_fifo.sv]
// Two-entry queue of command items between the front and the back.
// Uses rncw_pkg.
module rncw_fifo import rncw_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  rncw_cmd_t data_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      valid_o,
  output rncw_cmd_t data_o
);

  rncw_cmd_t   mem_q [2];
  logic        wp_q, rp_q;
  logic [1:0]  cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

[hw/rtl/rncw_back.sv]
// Back part of the walker: expands each command item into its events,
// one a cycle unless the output stalls, into the output register. Uses rncw_pkg.
module rncw_back import rncw_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cmd_valid_i,
  input  rncw_cmd_t        cmd_i,
  output logic             cmd_pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [2:0]       event_kind_o,
  output logic [LVL_W-1:0] nest_level_o,
  output logic [31:0]      chunk_id_o,
  output logic [31:0]      list_kind_o,
  output logic [31:0]      chunk_size_o,
  output logic [7:0]       payload_byte_o,
  output logic             last_o
);

  rncw_cmd_t        c_q, c_n;
  logic             busy_q;
  logic             ov_q;
  logic             emit;
  logic             fin_now;
  rncw_kind_e       k;
  logic [LVL_W-1:0] l;
  logic [31:0]      id, lk, sz;
  logic [7:0]       pb;
  logic [2:0]       ek_q;
  logic [LVL_W-1:0] nl_q;
  logic [31:0]      ci_q, lk_q, cs_q;
  logic [7:0]       pb_q;
  logic             last_q;

  assign emit = busy_q && (!ov_q || out_ready_i);

  always_comb begin
    c_n = c_q;
    k   = EV_END;
    l   = '0;
    id  = '0;
    lk  = '0;
    sz  = '0;
    pb  = '0;
    if (c_q.ufl_v) begin
      k         = EV_UNDERFLOW;
      l         = c_q.ufl_lvl;
      c_n.ufl_v = 1'b0;
    end else if (c_q.main_v) begin
      k          = c_q.kind;
      l          = c_q.lvl;
      id         = c_q.id;
      lk         = c_q.lk;
      sz         = c_q.size;
      pb         = c_q.pb;
      c_n.main_v = 1'b0;
    end else if (c_q.end_hi != c_q.end_lo) begin
      k          = EV_LIST_END;
      l          = c_q.end_hi;
      c_n.end_hi = c_q.end_hi - 1'b1;
    end else begin
      c_n.fin_v = 1'b0;
    end
    fin_now = !c_n.ufl_v && !c_n.main_v && !c_n.fin_v && (c_n.end_hi == c_n.end_lo);
  end

  assign cmd_pop_o = cmd_valid_i && (!busy_q || (emit && fin_now));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      ov_q   <= 1'b0;
    end else begin
      if (cmd_pop_o) busy_q <= 1'b1;
      else if (emit && fin_now) busy_q <= 1'b0;
      if (emit) ov_q <= 1'b1;
      else if (out_ready_i) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) c_q <= cmd_i;
    else if (emit) c_q <= c_n;
    if (emit) begin
      ek_q   <= k;
      nl_q   <= l;
      ci_q   <= id;
      lk_q   <= lk;
      cs_q   <= sz;
      pb_q   <= pb;
      last_q <= fin_now;
    end
  end

  assign out_valid_o    = ov_q;
  assign event_kind_o   = ek_q;
  assign nest_level_o   = nl_q;
  assign chunk_id_o     = ci_q;
  assign list_kind_o    = lk_q;
  assign chunk_size_o   = cs_q;
  assign payload_byte_o = pb_q;
  assign last_o         = last_q;

endmodule

[hw/rtl/rncw_checker.sv]
// Port-level checker of the walker, attached to the top level by bind.
// Uses rncw_pkg.
module rncw_checker import rncw_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input logic [2:0]       event_kind_o,
  input logic [LVL_W-1:0] nest_level_o,
  input logic [31:0]      chunk_id_o,
  input logic [31:0]      list_kind_o,
  input logic [31:0]      chunk_size_o,
  input logic [7:0]       payload_byte_o,
  input logic             last_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(event_kind_o))
    else $error("output item dropped while stalled");

  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (event_kind_o == EV_END || event_kind_o == EV_HDR_ERR) |-> last_o)
    else $error("end of stream is not the final event of its item");

  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (event_kind_o == EV_LIST_END || event_kind_o == EV_END)
    |-> chunk_id_o == '0 && chunk_size_o == '0 && list_kind_o == '0)
    else $error("list end or end carries chunk fields");

  a_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> nest_level_o < LVL_W'(MAX_LEVELS) &&
    (event_kind_o == EV_PAYLOAD || payload_byte_o == '0))
    else $error("bad level or stray payload byte");

endmodule

bind riff_nested_chunk_walker rncw_checker u_rncw_checker (.*);

[test/testbench.sv]
// Self-checking testbench of the RIFF nested chunk walker: builds one RIFF stream
// (directed chunks, then random nesting), predicts every event and checks it.
// Depends on rncw_pkg and riff_nested_chunk_walker.
`timescale 1ns / 1ps

typedef struct packed {
  logic [2:0]  kind;
  logic [3:0]  level;
  logic [31:0] id;
  logic [31:0] lkind;
  logic [31:0] size;
  logic [7:0]  pbyte;
  logic        last;
} walk_event_t;

class chunk_scoreboard;
  logic [31:0] fmt_word, file_len;
  int unsigned phase;
  int unsigned nbytes;
  logic [31:0] id_sr, size_sr, skip_left;
  int unsigned level;
  logic [31:0] remaining [rncw_pkg::MAX_LEVELS];
  bit done, id_bad;
  walk_event_t expected_q [$];
  walk_event_t step_q [$];
  int errors;

  function new();
    fmt_word = 0;
    file_len = 0;
    phase = rncw_pkg::PH_HDR;
    nbytes = 0;
    id_sr = 0;
    size_sr = 0;
    skip_left = 0;
    level = 0;
    foreach (remaining[i]) remaining[i] = 0;
    done = 0;
    id_bad = 0;
    errors = 0;
  endfunction

  function void add_event(rncw_pkg::rncw_kind_e k, int unsigned lv, logic [31:0] id,
                          logic [31:0] lk, logic [31:0] sz, logic [7:0] pb);
    walk_event_t e;
    if (step_q.size() >= 12) return;
    e.kind = k;
    e.level = lv[3:0];
    e.id = id;
    e.lkind = lk;
    e.size = sz;
    e.pbyte = pb;
    e.last = 1'b0;
    step_q.push_back(e);
  endfunction

  function void take_byte();
    int first;
    first = -1;
    for (int i = 0; i <= level && i < rncw_pkg::MAX_LEVELS; i++) begin
      if (remaining[i] != 0) remaining[i]--;
      else if (first < 0) first = i;
    end
    if (first >= 0) add_event(rncw_pkg::EV_UNDERFLOW, first, 0, 0, 0, 0);
  endfunction

  function void close_levels();
    while (level > 0 && level < rncw_pkg::MAX_LEVELS && remaining[level] == 0) begin
      add_event(rncw_pkg::EV_LIST_END, level, 0, 0, 0, 0);
      level--;
    end
    nbytes = 0;
    if (level == 0 && remaining[0] == 0) begin
      add_event(rncw_pkg::EV_END, 0, 0, 0, 0, 0);
      done = 1;
      phase = rncw_pkg::PH_DONE;
    end else begin
      phase = rncw_pkg::PH_ID;
    end
  endfunction

  function void begin_skip(logic [31:0] n, int unsigned next_phase);
    skip_left = n;
    if (n == 0) close_levels();
    else phase = next_phase;
  endfunction

  function void note_byte(logic [7:0] b);
    step_q.delete();
    if (done) return;
    case (phase)
      rncw_pkg::PH_HDR: begin
        if (nbytes < 4) id_sr = {b, id_sr[31:8]};
        else size_sr = {b, size_sr[31:8]};
        if (nbytes == 3) id_bad = (id_sr != rncw_pkg::CC_RIFF);
        nbytes++;
        if (nbytes >= 12) begin
          if (id_bad || size_sr != fmt_word || file_len < 12) begin
            add_event(rncw_pkg::EV_HDR_ERR, 0, 0, 0, 0, 0);
            done = 1;
            phase = rncw_pkg::PH_DONE;
          end else begin
            level = 0;
            remaining[0] = file_len - 12;
            close_levels();
          end
        end
      end
      rncw_pkg::PH_ID: begin
        take_byte();
        id_sr = {b, id_sr[31:8]};
        nbytes++;
        if (nbytes >= 4) begin
          nbytes = 0;
          if (id_sr == rncw_pkg::CC_LIST) phase = rncw_pkg::PH_LSIZE;
          else if (id_sr == rncw_pkg::CC_INFO) close_levels();
          else phase = rncw_pkg::PH_CSIZE;
        end
      end
      rncw_pkg::PH_LSIZE: begin
        take_byte();
        size_sr = {b, size_sr[31:8]};
        nbytes++;
        if (nbytes >= 4) begin
          nbytes = 0;
          if (level + 1 >= rncw_pkg::MAX_LEVELS) begin
            add_event(rncw_pkg::EV_OVERFLOW, level, rncw_pkg::CC_LIST, 0, size_sr, 0);
            begin_skip(size_sr, rncw_pkg::PH_SKIP);
          end else begin
            level++;
            remaining[level] = size_sr;
            id_sr = 0;
            phase = rncw_pkg::PH_LTYPE;
          end
        end
      end
      rncw_pkg::PH_LTYPE: begin
        take_byte();
        id_sr = {b, id_sr[31:8]};
        nbytes++;
        if (nbytes >= 4) begin
          nbytes = 0;
          add_event(rncw_pkg::EV_LIST, level, rncw_pkg::CC_LIST, id_sr, size_sr, 0);
          if (id_sr == rncw_pkg::CC_MOVI) begin_skip(remaining[level], rncw_pkg::PH_SKIP);
          else close_levels();
        end
      end
      rncw_pkg::PH_CSIZE: begin
        take_byte();
        size_sr = {b, size_sr[31:8]};
        nbytes++;
        if (nbytes >= 4) begin
          nbytes = 0;
          add_event(rncw_pkg::EV_CHUNK, level, id_sr, 0, size_sr, 0);
          begin_skip(size_sr, rncw_pkg::PH_PAYLOAD);
        end
      end
      rncw_pkg::PH_PAYLOAD, rncw_pkg::PH_SKIP: begin
        take_byte();
        if (phase == rncw_pkg::PH_PAYLOAD)
          add_event(rncw_pkg::EV_PAYLOAD, level, id_sr, 0, size_sr, b);
        if (skip_left != 0) skip_left--;
        if (skip_left == 0) close_levels();
      end
      default: begin
        done = 1;
        phase = rncw_pkg::PH_DONE;
      end
    endcase
    if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1'b1;
    foreach (step_q[i]) expected_q.push_back(step_q[i]);
  endfunction

  function void check_event(walk_event_t got);
    walk_event_t want;
    if (expected_q.size() == 0) begin
      errors++;
      if (errors <= 10) $display("Unexpected event: kind %0d level %0d", got.kind, got.level);
      return;
    end
    want = expected_q.pop_front();
    if (got !== want) begin
      errors++;
      if (errors <= 10) begin
        $display("Mismatch: expected kind %0d lvl %0d id %h lk %h size %h pb %h last %b,",
                 want.kind, want.level, want.id, want.lkind, want.size, want.pbyte,
                 want.last);
        $display("          got kind %0d lvl %0d id %h lk %h size %h pb %h last %b",
                 got.kind, got.level, got.id, got.lkind, got.size, got.pbyte, got.last);
      end
    end
  endfunction
endclass

module testbench;
  import rncw_pkg::*;

  logic        clk_i, rst_ni;
  logic        cfg_valid_i, cfg_ready_o;
  logic [7:0]  cfg_index_i;
  logic [31:0] cfg_data_i;
  logic        in_valid_i, in_ready_o;
  logic [7:0]  data_byte_i;
  logic        out_valid_o, out_ready_i;
  logic [2:0]  event_kind_o;
  logic [3:0]  nest_level_o;
  logic [31:0] chunk_id_o, list_kind_o, chunk_size_o;
  logic [7:0]  payload_byte_o;
  logic        last_o;

  chunk_scoreboard sb;
  logic [7:0] stream_q [$];
  int unsigned open_pos [$];
  int unsigned send_idle, recv_idle, hold_cycles, cycle_count;
  logic [31:0] fmt;

  riff_nested_chunk_walker u_top (.*);

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  function void put_word(logic [31:0] w);
    for (int i = 0; i < 4; i++) stream_q.push_back(w[8*i +: 8]);
  endfunction

  function void open_list(logic [31:0] ltype);
    put_word(CC_LIST);
    open_pos.push_back(stream_q.size());
    put_word(0);
    put_word(ltype);
  endfunction

  function void close_list(bit allow_bad);
    int unsigned p;
    logic [31:0] sz;
    p = open_pos.pop_back();
    sz = stream_q.size() - p - 4;
    if (allow_bad && $urandom_range(99) < 5) sz = sz + $urandom_range(2) - 1;
    for (int i = 0; i < 4; i++) stream_q[p + i] = sz[8*i +: 8];
  endfunction

  function void put_chunk(int unsigned n);
    put_word($urandom());
    put_word(n);
    repeat (n) stream_q.push_back($urandom_range(255));
  endfunction

  function void build_stream();
    logic [31:0] total;
    put_word(CC_RIFF);
    put_word(0);
    put_word(fmt);
    put_word(32'h6174_6164);
    put_word(3);
    stream_q.push_back(8'h00);
    stream_q.push_back(8'hFF);
    stream_q.push_back(8'h5A);
    put_word(CC_INFO);
    put_chunk(0);
    open_list(CC_MOVI);
    repeat (5) stream_q.push_back($urandom_range(255));
    close_list(0);
    repeat (10) open_list($urandom());
    put_chunk(2);
    repeat (10) close_list(0);
    while (stream_q.size() < 345) begin
      int unsigned r;
      r = $urandom_range(99);
      if (r < 20 && open_pos.size() < 11) begin
        open_list($urandom_range(9) == 0 ? CC_MOVI : $urandom());
      end else if (r < 35 && open_pos.size() > 0) begin
        close_list(1);
      end else if (r < 42) begin
        put_word(CC_INFO);
      end else begin
        put_chunk($urandom_range(9) == 0 ? $urandom_range(40) : $urandom_range(9));
      end
    end
    while (open_pos.size() > 0) close_list(0);
    total = stream_q.size() - 8;
    for (int i = 0; i < 4; i++) stream_q[4 + i] = total[8*i +: 8];
  endfunction

  task automatic write_reg(logic [7:0] idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_valid_i = 1;
    cfg_index_i = idx;
    cfg_data_i = val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == REG_FORMAT) sb.fmt_word = val;
    else if (idx == REG_LENGTH) sb.file_len = val;
    @(negedge clk_i);
    cfg_valid_i = 0;
  endtask

  task automatic send_byte(logic [7:0] b);
    while ($urandom_range(99) < send_idle) begin
      in_valid_i = 0;
      @(negedge clk_i);
    end
    in_valid_i = 1;
    data_byte_i = b;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic settle();
    in_valid_i = 0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_ready_i <= 0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk_i) begin
    walk_event_t got;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_byte(data_byte_i);
      if (out_valid_o && out_ready_i) begin
        got.kind = event_kind_o;
        got.level = nest_level_o;
        got.id = chunk_id_o;
        got.lkind = list_kind_o;
        got.size = chunk_size_o;
        got.pbyte = payload_byte_o;
        got.last = last_o;
        sb.check_event(got);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > 200000) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int unsigned third;
    sb = new();
    cycle_count = 0;
    hold_cycles = 0;
    send_idle = 17;
    recv_idle = 53;
    rst_ni = 0;
    cfg_valid_i = 0;
    cfg_index_i = 0;
    cfg_data_i = 0;
    in_valid_i = 0;
    data_byte_i = 0;
    out_ready_i = 0;
    fmt = $urandom();
    build_stream();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;
    write_reg(REG_FORMAT, 32'h0);
    write_reg(REG_LENGTH, 32'hFFFF_FFFF);
    write_reg(REG_FORMAT, 32'hFFFF_FFFF);
    write_reg(REG_LENGTH, 32'h0);
    write_reg(REG_FORMAT, fmt);
    write_reg(REG_LENGTH, stream_q.size());
    third = stream_q.size() / 3;
    for (int i = 0; i < stream_q.size(); i++) begin
      if (i == third || i == 2 * third) begin
        settle();
        if (i == third) begin
          write_reg(REG_LENGTH, $urandom());
          send_idle = 53;
          recv_idle = 17;
        end else begin
          write_reg(REG_FORMAT, $urandom());
          send_idle = 0;
          recv_idle = 0;
          hold_cycles = 400;
        end
      end
      send_byte(stream_q[i]);
    end
    settle();
    repeat (30) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

[filelist.f]
hw/rtl/rncw_pkg.sv
hw/rtl/rncw_front.sv
hw/rtl/rncw_fifo.sv
hw/rtl/rncw_back.sv
hw/rtl/riff_nested_chunk_walker.sv
hw/rtl/rncw_checker.sv
test/testbench.sv
